[hw/rtl/dtt_pkg.sv]
// ============================================================================
// dtt_pkg: shared types and constants of the deadline timer table
// Field widths, result and request codes, the stored entry layout and the
// sequencer state type.
// ============================================================================
`default_nettype none

package dtt_pkg;

    // Sizes
    localparam int TimerSlots = 16;
    localparam int MaxExpire  = 16;
    localparam int DlW        = 49;
    localparam int NowW       = 48;
    localparam int IvlW       = 32;
    localparam int NtoW       = 32;
    localparam int ExpCntW    = $clog2(MaxExpire + 1);
    localparam int FireIdxW   = $clog2(MaxExpire);

    // Request codes
    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_DEL = 2'd1;
    localparam logic [1:0] REQ_CHK = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ADD_ACK = 2'd0;
    localparam logic [1:0] KIND_DEL_ACK = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // One stored timer
    typedef struct packed {
        logic [DlW-1:0]  deadline;
        logic [DlW-1:0]  handle;
        logic [IvlW-1:0] interval;
        logic            periodic;
    } t_entry;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FULL,
        S_UNQ_SCAN,
        S_ADD_WR,
        S_DEL_SCAN,
        S_DEL_ACK,
        S_CHK_SCAN,
        S_CHK_EMIT,
        S_NXT_SCAN,
        S_NXT_CALC,
        S_RA_RD,
        S_RA_LD,
        S_RA_WR,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/dtt_ram.sv]
// ============================================================================
// dtt_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module dtt_ram #(
    parameter int WIDTH = $bits(dtt_pkg::t_entry),
    parameter int DEPTH = dtt_pkg::TimerSlots
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/deadline_timer_table_top.sv]
// ============================================================================
// deadline_timer_table_top: table of pending timers keyed by deadline
// Add, delete and expiry check on a RAM of timer entries, one slot per cycle.
// ============================================================================
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | in        | i_in_valid / o_in_stall    | req_type now_ms interval
//          |           |                            | periodic timer_id
//  out     | out       | o_out_valid / i_out_stall  | kind status result_id
//          |           |                            | was_periodic next_timeout last
//
//  One item at a time. A scan issues one RAM read per slot; read data is
//  registered. Add: a scan per key collision plus one, then a write. Delete:
//  one scan. Check: a scan per expired timer, one more unless MaxExpire fired,
//  one for the next deadline; per re-armed timer a read, load, key scans, write.
//  Reset clears the valid bits and control state; the RAM needs no clearing.
//  A stalled output holds the sequencer wherever it has a result to hand over.
// ============================================================================
`default_nettype none

module deadline_timer_table_top #(
    parameter int TIMER_SLOTS = dtt_pkg::TimerSlots
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [47:0] i_now_ms,
    input  wire logic [31:0] i_interval,
    input  wire logic        i_periodic,
    input  wire logic [48:0] i_timer_id,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [1:0]       o_status,
    output logic [48:0]      o_result_id,
    output logic             o_was_periodic,
    output logic [31:0]      o_next_timeout,
    output logic             o_last
);

    localparam int              IW      = $clog2(TIMER_SLOTS);
    localparam int              EW      = $bits(dtt_pkg::t_entry);
    localparam int              CW      = dtt_pkg::ExpCntW;
    localparam int              FW      = dtt_pkg::FireIdxW;
    localparam int              DW      = dtt_pkg::DlW;
    localparam logic [IW:0]     SlotCnt = (IW+1)'(TIMER_SLOTS);
    localparam logic [IW-1:0]   LastIdx = IW'(TIMER_SLOTS - 1);
    localparam logic [CW-1:0]   ExpMax  = CW'(dtt_pkg::MaxExpire);

    dtt_pkg::t_state r_state, n_state;

    logic [TIMER_SLOTS-1:0] r_valid, n_valid;
    logic [47:0]            r_now, n_now;
    logic [31:0]            r_ivl, n_ivl;
    logic                   r_per, n_per;
    logic [DW-1:0]          r_tid, n_tid;
    logic [DW-1:0]          r_key, n_key;
    logic [IW:0]            r_iss, n_iss;
    logic                   r_chk, n_chk;
    logic [IW-1:0]          r_cidx, n_cidx;
    logic                   r_hit, n_hit;
    logic                   r_ffound, n_ffound;
    logic [IW-1:0]          r_free, n_free;
    logic [DW-1:0]          r_best, n_best;
    logic [IW-1:0]          r_bidx, n_bidx;
    logic                   r_bper, n_bper;
    logic [CW-1:0]          r_nfired, n_nfired;
    logic [CW-1:0]          r_nper, n_nper;
    logic [CW-1:0]          r_ridx, n_ridx;
    logic [IW-1:0]          r_fired [dtt_pkg::MaxExpire];
    logic [IW-1:0]          n_fired [dtt_pkg::MaxExpire];
    logic                   r_rearm, n_rearm;
    dtt_pkg::t_entry        r_ent, n_ent;
    logic [31:0]            r_nto, n_nto;

    logic                   r_o_valid, n_o_valid;
    logic [1:0]             r_o_kind, n_o_kind;
    logic [1:0]             r_o_status, n_o_status;
    logic [DW-1:0]          r_o_id, n_o_id;
    logic                   r_o_per, n_o_per;
    logic [31:0]            r_o_nto, n_o_nto;
    logic                   r_o_last, n_o_last;

    // RAM ports
    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    dtt_pkg::t_entry        ram_wdata;
    logic [IW-1:0]          ram_raddr;
    dtt_pkg::t_entry        ram_rdata;
    logic [EW-1:0]          ram_rword;

    // Scan status
    logic                   in_xfer;
    logic                   out_free;
    logic                   is_scan;
    logic                   scan_end;
    logic                   cur_v;
    logic                   unq_hit;
    logic                   del_hit;
    logic                   due_hit;
    logic                   nxt_hit;
    logic                   tbl_full;
    logic [DW-1:0]          nto_diff;

    dtt_ram #(
        .WIDTH (EW),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rword)
    );

    assign ram_rdata = dtt_pkg::t_entry'(ram_rword);

    // Handshake status
    assign o_in_stall = (r_state != dtt_pkg::S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_o_valid || !i_out_stall;
    assign tbl_full   = &r_valid;

    // Per-slot compares on the word returned by the RAM
    assign is_scan  = (r_state == dtt_pkg::S_UNQ_SCAN) || (r_state == dtt_pkg::S_DEL_SCAN)
                   || (r_state == dtt_pkg::S_CHK_SCAN) || (r_state == dtt_pkg::S_NXT_SCAN);
    assign scan_end = r_chk && (r_cidx == LastIdx);
    assign cur_v    = r_chk && r_valid[r_cidx];
    assign unq_hit  = cur_v && (ram_rdata.deadline == r_key);
    assign del_hit  = cur_v && !r_hit
                   && ((ram_rdata.handle == r_tid) || (ram_rdata.deadline == r_tid));
    assign due_hit  = cur_v && (ram_rdata.deadline <= {1'b0, r_now})
                   && (!r_hit || (ram_rdata.deadline < r_best));
    assign nxt_hit  = cur_v && (!r_hit || (ram_rdata.deadline < r_best));
    assign nto_diff = r_best - {1'b0, r_now};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dtt_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (i_req_type)
                        dtt_pkg::REQ_ADD: n_state = tbl_full ? dtt_pkg::S_FULL
                                                             : dtt_pkg::S_UNQ_SCAN;
                        dtt_pkg::REQ_DEL: n_state = dtt_pkg::S_DEL_SCAN;
                        dtt_pkg::REQ_CHK: n_state = dtt_pkg::S_CHK_SCAN;
                        default:          n_state = dtt_pkg::S_IDLE;
                    endcase
                end
            end
            dtt_pkg::S_FULL, dtt_pkg::S_ADD_WR, dtt_pkg::S_DEL_ACK, dtt_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = dtt_pkg::S_IDLE;
                end
            end
            dtt_pkg::S_UNQ_SCAN: begin
                if (scan_end && !(r_hit || unq_hit)) begin
                    n_state = r_rearm ? dtt_pkg::S_RA_WR : dtt_pkg::S_ADD_WR;
                end
            end
            dtt_pkg::S_DEL_SCAN: begin
                if (scan_end) begin
                    n_state = dtt_pkg::S_DEL_ACK;
                end
            end
            dtt_pkg::S_CHK_SCAN: begin
                if (scan_end) begin
                    n_state = (r_hit || due_hit) ? dtt_pkg::S_CHK_EMIT : dtt_pkg::S_NXT_SCAN;
                end
            end
            dtt_pkg::S_CHK_EMIT: begin
                if (out_free) begin
                    n_state = (r_nfired + CW'(1) == ExpMax) ? dtt_pkg::S_NXT_SCAN
                                                            : dtt_pkg::S_CHK_SCAN;
                end
            end
            dtt_pkg::S_NXT_SCAN: begin
                if (scan_end) begin
                    n_state = dtt_pkg::S_NXT_CALC;
                end
            end
            dtt_pkg::S_NXT_CALC: begin
                n_state = (r_nper != '0) ? dtt_pkg::S_RA_RD : dtt_pkg::S_DONE;
            end
            dtt_pkg::S_RA_RD: n_state = dtt_pkg::S_RA_LD;
            dtt_pkg::S_RA_LD: n_state = dtt_pkg::S_UNQ_SCAN;
            dtt_pkg::S_RA_WR: begin
                n_state = (r_ridx + CW'(1) == r_nper) ? dtt_pkg::S_DONE : dtt_pkg::S_RA_RD;
            end
            default: n_state = dtt_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM ports and result register
    always_comb begin
        n_valid   = r_valid;
        n_now     = r_now;
        n_ivl     = r_ivl;
        n_per     = r_per;
        n_tid     = r_tid;
        n_key     = r_key;
        n_hit     = r_hit;
        n_ffound  = r_ffound;
        n_free    = r_free;
        n_best    = r_best;
        n_bidx    = r_bidx;
        n_bper    = r_bper;
        n_nfired  = r_nfired;
        n_nper    = r_nper;
        n_ridx    = r_ridx;
        n_fired   = r_fired;
        n_rearm   = r_rearm;
        n_ent     = r_ent;
        n_nto     = r_nto;

        n_o_valid  = r_o_valid && i_out_stall;
        n_o_kind   = r_o_kind;
        n_o_status = r_o_status;
        n_o_id     = r_o_id;
        n_o_per    = r_o_per;
        n_o_nto    = r_o_nto;
        n_o_last   = r_o_last;

        ram_we    = 1'b0;
        ram_waddr = r_free;
        ram_wdata = '{deadline: r_key, handle: r_key, interval: r_ivl, periodic: r_per};
        ram_raddr = r_fired[r_ridx[FW-1:0]];

        // Issue one slot read per cycle while scanning
        if (is_scan) begin
            ram_raddr = r_iss[IW-1:0];
            n_chk     = (r_iss != SlotCnt);
            n_iss     = r_iss + (IW+1)'(r_iss != SlotCnt);
            n_cidx    = r_iss[IW-1:0];
        end else begin
            n_chk     = 1'b0;
            n_iss     = '0;
            n_cidx    = r_cidx;
        end

        case (r_state)
            dtt_pkg::S_IDLE: begin
                // Capture the item
                if (in_xfer) begin
                    n_now    = i_now_ms;
                    n_ivl    = i_interval;
                    n_per    = i_periodic;
                    n_tid    = i_timer_id;
                    n_key    = {1'b0, i_now_ms} + DW'(i_interval);
                    n_hit    = 1'b0;
                    n_ffound = 1'b0;
                    n_nfired = '0;
                    n_nper   = '0;
                    n_ridx   = '0;
                    n_rearm  = 1'b0;
                end
            end
            dtt_pkg::S_FULL: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = dtt_pkg::KIND_ADD_ACK;
                    n_o_status = dtt_pkg::ST_FULL;
                    n_o_id     = '0;
                    n_o_per    = 1'b0;
                    n_o_nto    = '0;
                    n_o_last   = 1'b1;
                end
            end
            dtt_pkg::S_UNQ_SCAN: begin
                // Look for a key collision, note the first free slot
                if (unq_hit) begin
                    n_hit = 1'b1;
                end
                if (r_chk && !r_valid[r_cidx] && !r_ffound) begin
                    n_ffound = 1'b1;
                    n_free   = r_cidx;
                end
                // Bump the key and rescan on a collision
                if (scan_end && (r_hit || unq_hit)) begin
                    n_key = r_key + DW'(1);
                    n_hit = 1'b0;
                    n_iss = '0;
                    n_chk = 1'b0;
                end
            end
            dtt_pkg::S_ADD_WR: begin
                if (out_free) begin
                    ram_we           = 1'b1;
                    n_valid[r_free]  = 1'b1;
                    n_o_valid        = 1'b1;
                    n_o_kind         = dtt_pkg::KIND_ADD_ACK;
                    n_o_status       = dtt_pkg::ST_OK;
                    n_o_id           = r_key;
                    n_o_per          = 1'b0;
                    n_o_nto          = '0;
                    n_o_last         = 1'b1;
                end
            end
            dtt_pkg::S_DEL_SCAN: begin
                // Keep the lowest matching slot
                if (del_hit) begin
                    n_hit  = 1'b1;
                    n_free = r_cidx;
                end
            end
            dtt_pkg::S_DEL_ACK: begin
                if (out_free) begin
                    if (r_hit) begin
                        n_valid[r_free] = 1'b0;
                    end
                    n_o_valid  = 1'b1;
                    n_o_kind   = dtt_pkg::KIND_DEL_ACK;
                    n_o_status = r_hit ? dtt_pkg::ST_OK : dtt_pkg::ST_NOT_FOUND;
                    n_o_id     = '0;
                    n_o_per    = 1'b0;
                    n_o_nto    = '0;
                    n_o_last   = 1'b1;
                end
            end
            dtt_pkg::S_CHK_SCAN: begin
                // Track the earliest due timer
                if (due_hit) begin
                    n_hit  = 1'b1;
                    n_best = ram_rdata.deadline;
                    n_bidx = r_cidx;
                    n_bper = ram_rdata.periodic;
                end
                // Rewind the read counter for the scan that follows
                if (scan_end) begin
                    n_hit = 1'b0;
                    n_iss = '0;
                end
            end
            dtt_pkg::S_CHK_EMIT: begin
                // Emit and drop the expired timer, remember it for re-arm if periodic
                if (out_free) begin
                    n_valid[r_bidx] = 1'b0;
                    n_nfired        = r_nfired + CW'(1);
                    if (r_bper) begin
                        n_fired[r_nper[FW-1:0]] = r_bidx;
                        n_nper                  = r_nper + CW'(1);
                    end
                    n_hit      = 1'b0;
                    n_o_valid  = 1'b1;
                    n_o_kind   = dtt_pkg::KIND_EXPIRED;
                    n_o_status = dtt_pkg::ST_OK;
                    n_o_id     = r_best;
                    n_o_per    = r_bper;
                    n_o_nto    = '0;
                    n_o_last   = 1'b0;
                end
            end
            dtt_pkg::S_NXT_SCAN: begin
                // Track the nearest remaining deadline
                if (nxt_hit) begin
                    n_hit  = 1'b1;
                    n_best = ram_rdata.deadline;
                end
            end
            dtt_pkg::S_NXT_CALC: begin
                // Time to it, saturated to 32 bits
                if (r_hit && (r_best > {1'b0, r_now})) begin
                    n_nto = (nto_diff[DW-1:dtt_pkg::NtoW] != '0) ? '1
                                                                 : nto_diff[31:0];
                end else begin
                    n_nto = '0;
                end
            end
            dtt_pkg::S_RA_LD: begin
                // Hold the fired entry, form its new key
                n_ent   = ram_rdata;
                n_key   = {1'b0, r_now} + DW'(ram_rdata.interval);
                n_hit   = 1'b0;
                n_rearm = 1'b1;
            end
            dtt_pkg::S_RA_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_fired[r_ridx[FW-1:0]];
                ram_wdata = '{deadline: r_key, handle: r_ent.handle,
                              interval: r_ent.interval, periodic: r_ent.periodic};
                n_valid[r_fired[r_ridx[FW-1:0]]] = 1'b1;
                n_ridx    = r_ridx + CW'(1);
            end
            dtt_pkg::S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = dtt_pkg::KIND_DONE;
                    n_o_status = dtt_pkg::ST_OK;
                    n_o_id     = '0;
                    n_o_per    = 1'b0;
                    n_o_nto    = r_nto;
                    n_o_last   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dtt_pkg::S_IDLE;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
            r_chk     <= 1'b0;
            r_iss     <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_o_valid <= n_o_valid;
            r_chk     <= n_chk;
            r_iss     <= n_iss;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_ivl      <= n_ivl;
        r_per      <= n_per;
        r_tid      <= n_tid;
        r_key      <= n_key;
        r_cidx     <= n_cidx;
        r_hit      <= n_hit;
        r_ffound   <= n_ffound;
        r_free     <= n_free;
        r_best     <= n_best;
        r_bidx     <= n_bidx;
        r_bper     <= n_bper;
        r_nfired   <= n_nfired;
        r_nper     <= n_nper;
        r_ridx     <= n_ridx;
        r_fired    <= n_fired;
        r_rearm    <= n_rearm;
        r_ent      <= n_ent;
        r_nto      <= n_nto;
        r_o_kind   <= n_o_kind;
        r_o_status <= n_o_status;
        r_o_id     <= n_o_id;
        r_o_per    <= n_o_per;
        r_o_nto    <= n_o_nto;
        r_o_last   <= n_o_last;
    end

    assign o_out_valid    = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_status       = r_o_status;
    assign o_result_id    = r_o_id;
    assign o_was_periodic = r_o_per;
    assign o_next_timeout = r_o_nto;
    assign o_last         = r_o_last;

    // Checks
    a_add_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtt_pkg::S_ADD_WR) |-> (r_ffound && !r_valid[r_free]))
        else $error("add writes into an occupied slot");

    a_fired_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != dtt_pkg::S_IDLE) |-> (r_nper <= r_nfired && r_nfired <= ExpMax))
        else $error("expiry counters out of range");

    a_rearm_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtt_pkg::S_RA_WR) |-> (r_ridx < r_nper))
        else $error("re-arm index past fired list");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == dtt_pkg::KIND_EXPIRED) |-> !o_last)
        else $error("expired timer marked as final result");

endmodule

`default_nettype wire

[tb/dtt_checker.sv]
// ----------------------------------------------------------------------------
// dtt_checker: result predictor and comparator for the deadline timer table
// Watches both channels. Every accepted request updates a shadow timer table
// and queues the results it should cause. Every accepted result is compared
// field by field with the oldest queued result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtt_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [47:0] i_now_ms,
    input  wire logic [31:0] i_interval,
    input  wire logic        i_periodic,
    input  wire logic [48:0] i_timer_id,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [1:0]  i_status,
    input  wire logic [48:0] i_result_id,
    input  wire logic        i_was_periodic,
    input  wire logic [31:0] i_next_timeout,
    input  wire logic        i_last,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [48:0] id;
        logic        per;
        logic [31:0] nto;
        logic        last;
    } t_result;

    // Shadow timer table
    logic                     tbl_valid    [dtt_pkg::TimerSlots];
    logic [dtt_pkg::DlW-1:0]  tbl_deadline [dtt_pkg::TimerSlots];
    logic [dtt_pkg::DlW-1:0]  tbl_handle   [dtt_pkg::TimerSlots];
    logic [dtt_pkg::IvlW-1:0] tbl_interval [dtt_pkg::TimerSlots];
    logic                     tbl_periodic [dtt_pkg::TimerSlots];

    t_result expected_results[$];

    function automatic t_result mk(logic [1:0] k, logic [1:0] s, logic [48:0] id,
                                   logic per, logic [31:0] nto, logic last);
        t_result r;
        r.kind = k; r.status = s; r.id = id; r.per = per; r.nto = nto; r.last = last;
        return r;
    endfunction

    // Append one result to the tail of the expected queue
    function automatic void expect_result(t_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic logic [48:0] free_key(logic [48:0] key);
        logic hit;
        hit = 1'b1;
        while (hit) begin
            hit = 1'b0;
            for (int i = 0; i < dtt_pkg::TimerSlots; i++) begin
                if (tbl_valid[i] && tbl_deadline[i] == key) hit = 1'b1;
            end
            if (hit) key = key + 49'd1;
        end
        return key;
    endfunction

    // Apply one request to the shadow table and queue its results
    task automatic apply_request(logic [1:0] req, logic [47:0] now, logic [31:0] ivl,
                                 logic per, logic [48:0] tid);
        int          slot;
        int          fired[$];
        int          best;
        logic [48:0] key;
        logic [48:0] nearest;
        logic        have_next;
        logic [48:0] gap;
        slot = -1;
        case (req)
            dtt_pkg::REQ_ADD: begin
                for (int i = dtt_pkg::TimerSlots - 1; i >= 0; i--) begin
                    if (!tbl_valid[i]) slot = i;
                end
                if (slot < 0) begin
                    expect_result(mk(dtt_pkg::KIND_ADD_ACK, dtt_pkg::ST_FULL, '0, 1'b0, '0,
                                     1'b1));
                end else begin
                    key = free_key({1'b0, now} + {17'd0, ivl});
                    tbl_valid[slot] = 1'b1;
                    tbl_deadline[slot] = key;
                    tbl_handle[slot] = key;
                    tbl_interval[slot] = ivl;
                    tbl_periodic[slot] = per;
                    expect_result(mk(dtt_pkg::KIND_ADD_ACK, dtt_pkg::ST_OK, key, 1'b0, '0,
                                     1'b1));
                end
            end
            dtt_pkg::REQ_DEL: begin
                for (int i = 0; i < dtt_pkg::TimerSlots && slot < 0; i++) begin
                    if (tbl_valid[i] && (tbl_handle[i] == tid || tbl_deadline[i] == tid))
                        slot = i;
                end
                if (slot >= 0) tbl_valid[slot] = 1'b0;
                expect_result(mk(dtt_pkg::KIND_DEL_ACK,
                                 (slot >= 0) ? dtt_pkg::ST_OK : dtt_pkg::ST_NOT_FOUND,
                                 '0, 1'b0, '0, 1'b1));
            end
            dtt_pkg::REQ_CHK: begin
                // Drain due timers, earliest first, up to MaxExpire of them
                while (fired.size() < dtt_pkg::MaxExpire) begin
                    best = -1;
                    for (int i = 0; i < dtt_pkg::TimerSlots; i++) begin
                        if (tbl_valid[i] && tbl_deadline[i] <= {1'b0, now} &&
                            (best < 0 || tbl_deadline[i] < tbl_deadline[best]))
                            best = i;
                    end
                    if (best < 0) break;
                    tbl_valid[best] = 1'b0;
                    fired.insert(fired.size(), best);
                    expect_result(mk(dtt_pkg::KIND_EXPIRED, dtt_pkg::ST_OK, tbl_deadline[best],
                                     tbl_periodic[best], '0, 1'b0));
                end
                have_next = 1'b0;
                nearest = '0;
                for (int i = 0; i < dtt_pkg::TimerSlots; i++) begin
                    if (tbl_valid[i] && (!have_next || tbl_deadline[i] < nearest)) begin
                        have_next = 1'b1;
                        nearest = tbl_deadline[i];
                    end
                end
                gap = '0;
                if (have_next && nearest > {1'b0, now}) begin
                    gap = nearest - {1'b0, now};
                    if (gap > 49'hFFFF_FFFF) gap = 49'hFFFF_FFFF;
                end
                // Re-arm periodic timers after the timeout is known
                foreach (fired[j]) begin
                    if (tbl_periodic[fired[j]]) begin
                        tbl_deadline[fired[j]] =
                            free_key({1'b0, now} + {17'd0, tbl_interval[fired[j]]});
                        tbl_valid[fired[j]] = 1'b1;
                    end
                end
                expect_result(mk(dtt_pkg::KIND_DONE, dtt_pkg::ST_OK, '0, 1'b0, gap[31:0],
                                 1'b1));
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < dtt_pkg::TimerSlots; i++) tbl_valid[i] = 1'b0;
            expected_results.delete();
        end else begin
            // Check the result transfer before the request transfer of this edge
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                got = mk(i_kind, i_status, i_result_id, i_was_periodic, i_next_timeout, i_last);
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result exp none got %h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind)
                        $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
                    if (got.status != want.status)
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    if (got.id != want.id)
                        $display("%0t: id exp %h got %h", $time, want.id, got.id);
                    if (got.per != want.per)
                        $display("%0t: periodic exp %0d got %0d", $time, want.per, got.per);
                    if (got.nto != want.nto)
                        $display("%0t: timeout exp %0d got %0d", $time, want.nto, got.nto);
                    if (got.last != want.last)
                        $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
                    if (got != want) o_fail_count++;
                end
            end
            if (i_in_valid && !i_in_stall)
                apply_request(i_req_type, i_now_ms, i_interval, i_periodic, i_timer_id);
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_result_count = 0;
    end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the deadline timer table
// Drives adds, deletes and checks in bursts with gaps against a stalling
// receiver, with a directed opening that fills the table, deletes by id and
// forces collisions and extremes of time and interval.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    // Request code the block ignores
    localparam logic [1:0] ReqUnused = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [47:0] now_ms;
    logic [31:0] interval;
    logic        periodic;
    logic [48:0] timer_id;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [48:0] result_id;
    logic        was_periodic;
    logic [31:0] next_timeout;
    logic        last;
    int          fail_count;
    int          pending;
    int          result_count;

    logic [47:0] clock_ms;
    logic [48:0] known_ids[$];
    int          gap_left;
    int          burst_left;
    int          item_count;

    deadline_timer_table_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_req_type(req_type), .i_now_ms(now_ms), .i_interval(interval),
        .i_periodic(periodic), .i_timer_id(timer_id),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_kind(kind), .o_status(status), .o_result_id(result_id),
        .o_was_periodic(was_periodic), .o_next_timeout(next_timeout), .o_last(last)
    );

    dtt_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_req_type(req_type), .i_now_ms(now_ms), .i_interval(interval),
        .i_periodic(periodic), .i_timer_id(timer_id),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_kind(kind), .i_status(status), .i_result_id(result_id),
        .i_was_periodic(was_periodic), .i_next_timeout(next_timeout), .i_last(last),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver stall pattern: stretches of free flow, stretches of random stall
    initial begin
        int mode;
        out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(5, 60)) begin
                @(posedge clk);
                out_stall <= (mode == 0) ? 1'b0 :
                             (mode == 1) ? ($urandom_range(0, 3) == 0) :
                                           ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Send one request; keeps valid high into the next when the burst goes on
    task automatic send(logic [1:0] req, logic [47:0] now, logic [31:0] ivl,
                        logic per, logic [48:0] tid);
        if (gap_left > 0) begin
            in_valid <= 1'b0;
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        in_valid <= 1'b1;
        req_type <= req;
        now_ms <= now;
        interval <= ivl;
        periodic <= per;
        timer_id <= tid;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        item_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 6);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
    endtask

    task automatic finish_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Track ids handed out so deletes can hit
    always @(posedge clk) begin
        if (out_valid && !out_stall
            && (kind == dtt_pkg::KIND_ADD_ACK || kind == dtt_pkg::KIND_EXPIRED)
            && status == dtt_pkg::ST_OK) begin
            known_ids.insert(known_ids.size(), result_id);
            if (known_ids.size() > 40) void'(known_ids.pop_front());
        end
    end

    function automatic logic [48:0] pick_id();
        if (known_ids.size() > 0 && $urandom_range(0, 4) != 0)
            return known_ids[$urandom_range(0, known_ids.size() - 1)];
        return 49'({$urandom(), $urandom()});
    endfunction

    initial begin
        logic [47:0] top_now;
        int          r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = dtt_pkg::REQ_ADD;
        now_ms = '0;
        interval = '0;
        periodic = 1'b0;
        timer_id = '0;
        gap_left = 0;
        burst_left = 0;
        item_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: collisions, full table, extremes of time and interval
        send(dtt_pkg::REQ_CHK, 48'd0, 32'd0, 1'b0, '0);
        send(dtt_pkg::REQ_DEL, 48'd0, 32'd0, 1'b0, 49'h1_FFFF_FFFF_FFFF);
        for (int i = 0; i < 16; i++)
            send(dtt_pkg::REQ_ADD, 48'd100, (i < 6) ? 32'd5 : 32'hFFFF_FFFF, i[0], '0);
        send(dtt_pkg::REQ_ADD, 48'd100, 32'd1, 1'b1, '0);
        send(dtt_pkg::REQ_DEL, 48'd0, 32'd0, 1'b0, 49'd105);
        send(dtt_pkg::REQ_DEL, 48'd0, 32'd0, 1'b0, 49'd106);
        send(dtt_pkg::REQ_CHK, 48'd110, 32'd0, 1'b0, '0);
        send(dtt_pkg::REQ_CHK, 48'd110, 32'd0, 1'b0, '0);
        send(dtt_pkg::REQ_ADD, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0);
        send(dtt_pkg::REQ_ADD, 48'd200, 32'd0, 1'b1, '0);
        send(dtt_pkg::REQ_CHK, 48'd200, 32'd0, 1'b0, '0);
        send(ReqUnused, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 49'h1_FFFF_FFFF_FFFF);
        send(dtt_pkg::REQ_CHK, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b0, '0);

        // Random: time advances slowly so timers both collide and expire
        clock_ms = 48'd1000;
        for (int n = 0; n < 200; n++) begin
            r = $urandom_range(0, 99);
            clock_ms = clock_ms + 48'($urandom_range(0, 20));
            if (r < 2) begin
                top_now = 48'({$urandom(), $urandom()});
                send(dtt_pkg::REQ_ADD, top_now, $urandom(), 1'($urandom_range(0, 1)), '0);
            end else if (r < 45) begin
                send(dtt_pkg::REQ_ADD, clock_ms,
                     ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 40),
                     1'($urandom_range(0, 1)), '0);
            end else if (r < 65) begin
                send(dtt_pkg::REQ_DEL, clock_ms, $urandom(), 1'($urandom_range(0, 1)),
                     pick_id());
            end else if (r < 97) begin
                send(dtt_pkg::REQ_CHK, clock_ms, $urandom(), 1'($urandom_range(0, 1)),
                     49'({$urandom(), $urandom()}));
            end else begin
                send(ReqUnused, clock_ms, $urandom(), 1'b0, '0);
            end
        end
        // Flush everything pending with a far-future check
        send(dtt_pkg::REQ_CHK, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b0, '0);
        finish_sending();

        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Sent %0d requests, checked %0d results.", item_count, result_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Timed out.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[deadline_timer_table_top.f]
hw/rtl/dtt_pkg.sv
hw/rtl/dtt_ram.sv
hw/rtl/deadline_timer_table_top.sv
tb/dtt_checker.sv
tb/tb.sv
